>>> hdl/gs4_pkg.sv
// Package with types and constants of the 4x4 Gauss-Seidel solver.
package gs4_pkg;
	localparam int FRAC_BITS = 16;
	localparam int MAX_ITERATIONS = 63;
	localparam int N = 4;
	localparam int COEF_DEPTH = 20;
	localparam int COEF_AW = 5;
	localparam int RHS_COL = 4;
	localparam logic [1:0] OP_LOAD_COEF = 2'd0;
	localparam logic [1:0] OP_LOAD_GUESS = 2'd1;
	localparam logic [1:0] OP_RUN = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [31:0] POS_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] NEG_MIN = 32'sh80000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_READ,
		ST_MAC,
		ST_DIV,
		ST_WRITE
	} state_t;

	// Handshake between the sequencer and the divider.
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

>>> hdl/gauss_seidel_4x4_solver.sv
// Top level of the 4x4 Gauss-Seidel solver.
//  channel | signals                                  | direction
//  input   | in_valid in_stall op row col value iterations | in
//  output  | out_valid out_stall step x_* divide_fault last | out
// Load items may come back to back while the sequencer is idle and no result is stalled.
// A sweep row takes a read setup state, coefficient reads and products for columns 0..4,
// the divider (start, 80 quotient bits, done; no quotient bits on a zero diagonal) and a write.
// Each sweep ends with its result; a run holds the input until its last result is issued.
// Reset clears the control, the guesses and the working vector; the
// coefficient memory is not cleared. A stalled result holds the sequencer when it reaches the next result.
module gauss_seidel_4x4_solver import gs4_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [1:0]         row,
	input  logic [2:0]         col,
	input  logic signed [31:0] value,
	input  logic [5:0]         iterations,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         step,
	output logic signed [31:0] x_first,
	output logic signed [31:0] x_second,
	output logic signed [31:0] x_third,
	output logic signed [31:0] x_fourth,
	output logic               divide_fault,
	output logic               last
);
	state_t state_q, state_d;
	logic signed [31:0] guess_q [N];
	logic signed [31:0] x_q [N];
	logic               fault_q;
	logic [5:0]         iters_q;
	logic [5:0]         iter_q;
	logic [1:0]         r_q;
	logic [2:0]         c_q;
	logic [2:0]         cr_q;
	logic               rd_v_s1;
	logic signed [63:0] acc_q;
	logic signed [31:0] diag_q;
	logic signed [63:0] prod_s2;
	logic               prod_v_s2;
	logic [2:0]         prod_c_s2;
	logic               div_go_q;
	logic               accept;
	logic               out_take;
	logic               div_start;
	logic               emit_go;
	logic [COEF_AW-1:0] raddr;
	logic [COEF_AW-1:0] waddr;
	logic               we;
	logic [31:0]        rdata;
	logic signed [31:0] quot;
	logic               zden;
	div_ctl_t           dctl;
	logic [5:0]         iters_clamp;
	logic [1:0]         prod_r;

	assign accept = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid && out_stall);
	assign iters_clamp = (iterations > 6'(MAX_ITERATIONS)) ? 6'(MAX_ITERATIONS) : iterations;

	// Coefficient memory: write on loads, read during sweeps.
	assign we = accept && (op == OP_LOAD_COEF) && (col <= 3'(RHS_COL));
	assign waddr = COEF_AW'({3'b000, row} * 5 + {2'b00, col});
	assign raddr = COEF_AW'({3'b000, r_q} * 5 + {2'b00, c_q});

	gs4_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef (
		.clk(clk), .we(we), .waddr(waddr), .wdata(value),
		.raddr(raddr), .rdata(rdata)
	);

	gs4_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(acc_q), .den(diag_q),
		.ctl(dctl), .quot(quot), .zero_den(zden)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_RUN) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid || out_take) begin
					state_d = (iter_q == iters_q) ? ST_IDLE : ST_READ;
				end
			end
			ST_READ: state_d = ST_MAC;
			ST_MAC: begin
				if (prod_v_s2 && prod_c_s2 == 3'(RHS_COL)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (dctl.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = (r_q == 2'(N - 1)) ? ST_EMIT : ST_READ;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		emit_go = 1'b0;
		unique case (state_q)
			ST_EMIT: emit_go = !out_valid || out_take;
			default: begin
			end
		endcase
	end

	// The divider starts in the cycle after the last product, once the numerator is complete.
	assign div_start = div_go_q;

	assign prod_r = r_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			fault_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			prod_v_s2 <= 1'b0;
			div_go_q <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			iter_q <= '0;
			iters_q <= '0;
			for (int i = 0; i < N; i++) begin
				guess_q[i] <= '0;
				x_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept && op == OP_LOAD_GUESS) begin
				guess_q[row] <= value;
			end
			if (accept && op == OP_RUN) begin
				for (int i = 0; i < N; i++) begin
					x_q[i] <= guess_q[i];
				end
				fault_q <= 1'b0;
				iter_q <= '0;
				iters_q <= iters_clamp;
			end
			if (emit_go) begin
				out_valid <= 1'b1;
				r_q <= '0;
				c_q <= '0;
			end else if (out_take) begin
				out_valid <= 1'b0;
			end
			// Read column addresses 0..4 of the current row, one a cycle.
			rd_v_s1 <= 1'b0;
			if ((state_q == ST_READ) || (state_q == ST_MAC && c_q != 3'd0)) begin
				rd_v_s1 <= 1'b1;
				c_q <= (c_q == 3'(RHS_COL)) ? 3'd0 : c_q + 3'd1;
			end
			prod_v_s2 <= rd_v_s1;
			div_go_q <= (state_q == ST_MAC) && prod_v_s2 && (prod_c_s2 == 3'(RHS_COL));
			if (state_q == ST_WRITE) begin
				x_q[r_q] <= quot;
				if (zden) begin
					fault_q <= 1'b1;
				end
				if (r_q == 2'(N - 1)) begin
					iter_q <= iter_q + 6'd1;
				end else begin
					r_q <= r_q + 2'd1;
				end
			end
		end
	end

	// Product stage and accumulator for the current row.
	always_ff @(posedge clk) begin
		cr_q <= c_q;
		prod_c_s2 <= cr_q;
		if (rd_v_s1) begin
			if (cr_q == 3'(RHS_COL)) begin
				prod_s2 <= 64'($signed(rdata));
			end else begin
				prod_s2 <= ($signed(rdata) * x_q[cr_q[1:0]]) >>> FRAC_BITS;
			end
			if (cr_q[1:0] == prod_r && cr_q != 3'(RHS_COL)) begin
				diag_q <= $signed(rdata);
			end
		end
		if (state_q == ST_READ) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			if (prod_c_s2 == 3'(RHS_COL)) begin
				acc_q <= prod_s2 - acc_q;
			end else if (prod_c_s2[1:0] != prod_r) begin
				acc_q <= acc_q + prod_s2;
			end
		end
		if (emit_go) begin
			step <= iter_q;
			x_first <= x_q[0];
			x_second <= x_q[1];
			x_third <= x_q[2];
			x_fourth <= x_q[3];
			divide_fault <= fault_q;
			last <= (iter_q == iters_q);
		end
	end
endmodule

>>> hdl/gs4_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module gs4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 20,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/gs4_div.sv
// Restoring divider giving a saturated signed fixed-point quotient.
module gs4_div import gs4_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [31:0] den,
	output div_ctl_t           ctl,
	output logic signed [31:0] quot,
	output logic               zero_den
);
	// Dividend magnitude is shifted left by FRAC_BITS; 64+FRAC_BITS bits of quotient.
	localparam int QW = 64 + FRAC_BITS;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] dvd_q;
	logic [QW-1:0] q_q;
	logic [32:0]   rem_q;
	logic [31:0]   ud_q;
	logic          neg_q;
	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          zden_q;
	logic          npos_q;
	logic          nneg_q;

	logic [63:0] un;
	logic [31:0] ud;
	logic [33:0] trial;
	logic [32:0] shifted;

	assign un = num[63] ? 64'(-num) : 64'(num);
	assign ud = den[31] ? 32'(-den) : 32'(den);
	assign shifted = {rem_q[31:0], dvd_q[QW-1]};
	assign trial = {1'b0, shifted} - {2'b00, ud_q};

	// One quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= (den != 32'sd0);
				done_q <= (den == 32'sd0);
				cnt_q <= CW'(QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the divider.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {un, {FRAC_BITS{1'b0}}};
			q_q <= '0;
			rem_q <= '0;
			ud_q <= ud;
			neg_q <= num[63] ^ den[31];
			zden_q <= (den == 32'sd0);
			npos_q <= !num[63] && (num != 64'sd0);
			nneg_q <= num[63];
		end else if (run_q) begin
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q <= {q_q[QW-2:0], 1'b0};
			end
		end
	end

	// Saturate and apply the sign; a zero denominator gives the limit of the numerator's sign, or zero.
	always_comb begin
		if (zden_q) begin
			quot = npos_q ? POS_MAX : (nneg_q ? NEG_MIN : 32'sd0);
		end else if (q_q[QW-1:31] != '0) begin
			quot = neg_q ? NEG_MIN : POS_MAX;
		end else if (neg_q) begin
			quot = 32'(-$signed({1'b0, q_q[30:0]}));
		end else begin
			quot = {1'b0, q_q[30:0]};
		end
	end

	assign zero_den = zden_q;
	assign ctl.start = start;
	assign ctl.busy = run_q;
	assign ctl.done = done_q;
endmodule

>>> hdl/gs4_checker.sv
// Port checker for the solver, bound to the top level.
module gs4_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] step,
	input logic       last
);
	// A stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(step))
		else $error("stalled result changed");

	// A result waiting blocks new input.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result stalled");

	// While a result that is not last is taken, the run still holds the input.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |-> in_stall)
		else $error("run ended early");
endmodule

bind gauss_seidel_4x4_solver gs4_checker u_gs4_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .step(step), .last(last)
);
